// ===== rtl/core/mcpi_pkg.sv =====
// Shared types and constants for the motor current PI controller.
// Used by mcpi_csr, mcpi_ctrl, mcpi_datapath and the top level; no dependencies.
`default_nettype none

package mcpi_pkg;

   // Field widths
   localparam int SENSE_W  = 16;
   localparam int SPEED_W  = 20;
   localparam int TARGET_W = 16;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 20;
   localparam int DUTY_W   = 12;

   // Datapath widths
   localparam int ERR_W    = 18;               // target - measured
   localparam int INTEG_W  = 21;               // stored integral
   localparam int MUL_A_W  = GAIN_W + 1;       // gain, zero extended to signed
   localparam int MUL_B_W  = 33;               // signed operand / magnitude chunk
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int SUM_W    = 48;               // Q16 volts sum, |S| < 2^45
   localparam int MAG_W    = SUM_W - 1;
   localparam int LO_W     = 32;               // low chunk of magnitude
   localparam int HI_W     = MAG_W - LO_W;     // high chunk of magnitude
   localparam int SCALED_W = MAG_W + GAIN_W;   // magnitude * supply reciprocal
   localparam int T_W      = SCALED_W - 16;    // after >> 16
   localparam int X_W      = T_W + 5;          // t * 30
   localparam int RAW_W    = X_W - 20;         // after >> 20

   // Register map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
   localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
   localparam logic [2:0] REG_INTEG_LIM  = 3'd2;
   localparam logic [2:0] REG_DUTY_LIM   = 3'd3;
   localparam logic [2:0] REG_RES_GAIN   = 3'd4;
   localparam logic [2:0] REG_BEMF_GAIN  = 3'd5;
   localparam logic [2:0] REG_SUPPLY_RCP = 3'd6;

   typedef struct packed {
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  integ_gain;
      logic [LIMIT_W-1:0] integ_limit;
      logic [DUTY_W-1:0]  duty_limit;
      logic [GAIN_W-1:0]  resistance_gain;
      logic [GAIN_W-1:0]  back_emf_gain;
      logic [GAIN_W-1:0]  supply_recip;
   } cfg_type;

   // One step strobe per datapath operation
   typedef struct packed {
      logic capture;    // take the input word, read the integral
      logic integ;      // update integral, start resistance product
      logic mul_p;      // add proportional term
      logic mul_i;      // add integral term
      logic mul_b;      // add back-EMF term
      logic abs_val;    // sign and magnitude of the sum
      logic scl_lo;     // low chunk times supply reciprocal
      logic scl_hi;     // high chunk times supply reciprocal
      logic out_load;   // duty conversion into the output register
   } cmd_type;

   typedef struct packed {
      logic out_free;   // output register can take a word this cycle
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/mcpi_csr.sv =====
// Configuration registers of the PI controller behind an APB-style port.
// Depends on mcpi_pkg for the register map and the cfg_type struct.
`default_nettype none

module mcpi_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [mcpi_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [mcpi_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [mcpi_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                     csr_pready,
   output mcpi_pkg::cfg_type                        cfg
);

   mcpi_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        reg_idx;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[mcpi_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            mcpi_pkg::REG_PROP_GAIN:  cfg_in.prop_gain       = csr_pwdata[15:0];
            mcpi_pkg::REG_INTEG_GAIN: cfg_in.integ_gain      = csr_pwdata[15:0];
            mcpi_pkg::REG_INTEG_LIM:  cfg_in.integ_limit     = csr_pwdata[19:0];
            mcpi_pkg::REG_DUTY_LIM:   cfg_in.duty_limit      = csr_pwdata[11:0];
            mcpi_pkg::REG_RES_GAIN:   cfg_in.resistance_gain = csr_pwdata[15:0];
            mcpi_pkg::REG_BEMF_GAIN:  cfg_in.back_emf_gain   = csr_pwdata[15:0];
            mcpi_pkg::REG_SUPPLY_RCP: cfg_in.supply_recip    = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain       <= 16'd1024;
         cfg_ff.integ_gain      <= 16'd102;
         cfg_ff.integ_limit     <= 20'd6554;
         cfg_ff.duty_limit      <= 12'd4095;
         cfg_ff.resistance_gain <= 16'd512;
         cfg_ff.back_emf_gain   <= 16'd0;
         cfg_ff.supply_recip    <= 16'd5461;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         mcpi_pkg::REG_PROP_GAIN:  csr_prdata = 32'(cfg_ff.prop_gain);
         mcpi_pkg::REG_INTEG_GAIN: csr_prdata = 32'(cfg_ff.integ_gain);
         mcpi_pkg::REG_INTEG_LIM:  csr_prdata = 32'(cfg_ff.integ_limit);
         mcpi_pkg::REG_DUTY_LIM:   csr_prdata = 32'(cfg_ff.duty_limit);
         mcpi_pkg::REG_RES_GAIN:   csr_prdata = 32'(cfg_ff.resistance_gain);
         mcpi_pkg::REG_BEMF_GAIN:  csr_prdata = 32'(cfg_ff.back_emf_gain);
         mcpi_pkg::REG_SUPPLY_RCP: csr_prdata = 32'(cfg_ff.supply_recip);
         default:                  csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/mcpi_ctrl.sv =====
// Step sequencer of the PI controller: walks one word through the datapath.
// Depends on mcpi_pkg for the command and status structs.
`default_nettype none

module mcpi_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  mcpi_pkg::sts_type      sts,
   output mcpi_pkg::cmd_type      cmd
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_INTEG  = 9'b000000010,
      ST_MUL_P  = 9'b000000100,
      ST_MUL_I  = 9'b000001000,
      ST_MUL_B  = 9'b000010000,
      ST_ABS    = 9'b000100000,
      ST_SCL_LO = 9'b001000000,
      ST_SCL_HI = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_INTEG;
         ST_INTEG:  state_in = ST_MUL_P;
         ST_MUL_P:  state_in = ST_MUL_I;
         ST_MUL_I:  state_in = ST_MUL_B;
         ST_MUL_B:  state_in = ST_ABS;
         ST_ABS:    state_in = ST_SCL_LO;
         ST_SCL_LO: state_in = ST_SCL_HI;
         ST_SCL_HI: state_in = ST_OUT;
         ST_OUT:    if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Step strobes
   always_comb begin
      cmd.capture  = (state_ff == ST_IDLE) && req_tvalid;
      cmd.integ    = (state_ff == ST_INTEG);
      cmd.mul_p    = (state_ff == ST_MUL_P);
      cmd.mul_i    = (state_ff == ST_MUL_I);
      cmd.mul_b    = (state_ff == ST_MUL_B);
      cmd.abs_val  = (state_ff == ST_ABS);
      cmd.scl_lo   = (state_ff == ST_SCL_LO);
      cmd.scl_hi   = (state_ff == ST_SCL_HI);
      cmd.out_load = (state_ff == ST_OUT) && sts.out_free;
   end

endmodule

`default_nettype wire

// ===== rtl/core/mcpi_datapath.sv =====
// Datapath of the PI controller: integral store, shared multiplier, accumulator,
// supply scaling, duty clamp and output register. Depends on mcpi_pkg.
`default_nettype none

module mcpi_datapath #(
   parameter int MOTOR_COUNT = 2
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  mcpi_pkg::cfg_type                          cfg,
   input  mcpi_pkg::cmd_type                          cmd,
   output mcpi_pkg::sts_type                          sts,
   input  wire logic                                  req_motor,
   input  wire logic        [mcpi_pkg::SENSE_W-1:0]   req_sense_code,
   input  wire logic signed [mcpi_pkg::SPEED_W-1:0]   req_encoder_speed,
   input  wire logic signed [mcpi_pkg::TARGET_W-1:0]  req_target_current,
   input  wire logic                                  rsp_tready,
   output logic                                       rsp_tvalid,
   output logic                                       rsp_motor_number,
   output logic             [mcpi_pkg::DUTY_W-1:0]    rsp_duty_magnitude,
   output logic                                       rsp_reverse_dir,
   output logic                                       rsp_duty_clipped
);

   localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

   localparam int ERR_W    = mcpi_pkg::ERR_W;
   localparam int INTEG_W  = mcpi_pkg::INTEG_W;
   localparam int SUM_W    = mcpi_pkg::SUM_W;
   localparam int MAG_W    = mcpi_pkg::MAG_W;
   localparam int LO_W     = mcpi_pkg::LO_W;
   localparam int HI_W     = mcpi_pkg::HI_W;
   localparam int SCALED_W = mcpi_pkg::SCALED_W;
   localparam int T_W      = mcpi_pkg::T_W;
   localparam int X_W      = mcpi_pkg::X_W;
   localparam int RAW_W    = mcpi_pkg::RAW_W;
   localparam int DUTY_W   = mcpi_pkg::DUTY_W;

   // Integral store with per-entry valid bits (cleared by reset)
   logic signed [INTEG_W-1:0] integ_mem [MOTOR_COUNT];
   logic [MOTOR_COUNT-1:0]    integ_vld_ff;

   logic [IDX_W-1:0] req_idx, idx_ff;
   logic             req_ok;

   // Item registers
   logic                                 motor_ff, motor_in;
   logic                                 ok_ff, ok_in;
   logic signed [mcpi_pkg::TARGET_W-1:0] target_ff, target_in;
   logic signed [mcpi_pkg::SPEED_W-1:0]  speed_ff, speed_in;
   logic signed [ERR_W-1:0]              err_ff, err_in;
   logic signed [INTEG_W-1:0]            rd_ff;
   logic signed [INTEG_W-1:0]            integ_ff, integ_in;
   logic signed [SUM_W-1:0]              acc_ff, acc_in;
   logic                                 rev_ff, rev_in;
   logic [MAG_W-1:0]                     mag_ff, mag_in;
   logic [SCALED_W-1:0]                  scaled_ff, scaled_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_motor_ff, rsp_motor_in;
   logic [DUTY_W-1:0] rsp_duty_ff, rsp_duty_in;
   logic              rsp_rev_ff, rsp_rev_in;
   logic              rsp_clip_ff, rsp_clip_in;

   // Shared multiplier
   logic signed [mcpi_pkg::MUL_A_W-1:0] mul_a;
   logic signed [mcpi_pkg::MUL_B_W-1:0] mul_b;
   logic signed [mcpi_pkg::PROD_W-1:0]  prod;
   logic signed [SUM_W-1:0]             prod_q8;

   // Integral clamp
   logic signed [INTEG_W:0] isum, ilim, nlim;

   // Duty conversion
   logic [T_W-1:0]   t_val;
   logic [X_W-1:0]   x_val;
   logic [RAW_W-1:0] raw_val;
   logic             clip_val;

   assign req_idx = IDX_W'(req_motor);
   assign req_ok  = (32'(req_motor) < MOTOR_COUNT);

   // Operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.integ) begin
         mul_a = {1'b0, cfg.resistance_gain};
         mul_b = {{17{target_ff[15]}}, target_ff};
      end
      if (cmd.mul_p) begin
         mul_a = {1'b0, cfg.prop_gain};
         mul_b = {{15{err_ff[ERR_W-1]}}, err_ff};
      end
      if (cmd.mul_i) begin
         mul_a = {1'b0, cfg.integ_gain};
         mul_b = {{12{integ_ff[INTEG_W-1]}}, integ_ff};
      end
      if (cmd.mul_b) begin
         mul_a = {1'b0, cfg.back_emf_gain};
         mul_b = {{13{speed_ff[19]}}, speed_ff};
      end
      if (cmd.scl_lo) begin
         mul_a = {1'b0, cfg.supply_recip};
         mul_b = {1'b0, mag_ff[LO_W-1:0]};
      end
      if (cmd.scl_hi) begin
         mul_a = {1'b0, cfg.supply_recip};
         mul_b = {{(mcpi_pkg::MUL_B_W-HI_W){1'b0}}, mag_ff[MAG_W-1:LO_W]};
      end
   end

   assign prod    = mul_a * mul_b;
   assign prod_q8 = {prod[SUM_W-9:0], 8'd0};

   // Clamp of integral plus error to the limit
   always_comb begin
      isum = {rd_ff[INTEG_W-1], rd_ff} + {{4{err_ff[ERR_W-1]}}, err_ff};
      ilim = {2'b00, cfg.integ_limit};
      nlim = -ilim;
   end

   // Duty from the scaled magnitude: raw = (t * 30) >> 20
   always_comb begin
      t_val    = scaled_ff[SCALED_W-1:16];
      x_val    = {t_val, 5'd0} - {4'd0, t_val, 1'd0};
      raw_val  = x_val[X_W-1:20];
      clip_val = raw_val > RAW_W'(cfg.duty_limit);
   end

   // Step updates
   always_comb begin
      motor_in  = motor_ff;
      ok_in     = ok_ff;
      target_in = target_ff;
      speed_in  = speed_ff;
      err_in    = err_ff;
      integ_in  = integ_ff;
      acc_in    = acc_ff;
      rev_in    = rev_ff;
      mag_in    = mag_ff;
      scaled_in = scaled_ff;
      if (cmd.capture) begin
         motor_in  = req_motor;
         ok_in     = req_ok;
         target_in = req_target_current;
         speed_in  = req_encoder_speed;
         // error = target - (32768 - code)
         err_in    = {{2{req_target_current[15]}}, req_target_current}
                   + {2'b00, req_sense_code} - 18'd32768;
      end
      if (cmd.integ) begin
         if (isum > ilim) begin
            integ_in = ilim[INTEG_W-1:0];
         end else if (isum < nlim) begin
            integ_in = nlim[INTEG_W-1:0];
         end else begin
            integ_in = isum[INTEG_W-1:0];
         end
         acc_in = prod_q8;
      end
      if (cmd.mul_p || cmd.mul_i) begin
         acc_in = acc_ff + prod_q8;
      end
      if (cmd.mul_b) begin
         acc_in = acc_ff + prod[SUM_W-1:0];
      end
      if (cmd.abs_val) begin
         rev_in = acc_ff[SUM_W-1];
         mag_in = acc_ff[SUM_W-1] ? MAG_W'(-acc_ff) : acc_ff[MAG_W-1:0];
      end
      if (cmd.scl_lo) begin
         scaled_in = SCALED_W'(prod[LO_W+16-1:0]);
      end
      if (cmd.scl_hi) begin
         scaled_in = scaled_ff + {prod[HI_W+16-1:0], {LO_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      motor_ff  <= motor_in;
      ok_ff     <= ok_in;
      target_ff <= target_in;
      speed_ff  <= speed_in;
      err_ff    <= err_in;
      integ_ff  <= integ_in;
      acc_ff    <= acc_in;
      rev_ff    <= rev_in;
      mag_ff    <= mag_in;
      scaled_ff <= scaled_in;
   end

   // Integral store: read on capture, write back on the integral step
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff <= req_idx;
         rd_ff  <= (req_ok && integ_vld_ff[req_idx]) ? integ_mem[req_idx] : '0;
      end
      if (cmd.integ && ok_ff) begin
         integ_mem[idx_ff] <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_vld_ff <= '0;
      end else if (cmd.integ && ok_ff) begin
         integ_vld_ff[idx_ff] <= 1'b1;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);
      rsp_motor_in = rsp_motor_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_rev_in   = rsp_rev_ff;
      rsp_clip_in  = rsp_clip_ff;
      if (cmd.out_load) begin
         rsp_motor_in = motor_ff;
         rsp_rev_in   = ok_ff && rev_ff;
         rsp_clip_in  = ok_ff && clip_val;
         if (!ok_ff) begin
            rsp_duty_in = '0;
         end else if (clip_val) begin
            rsp_duty_in = cfg.duty_limit;
         end else begin
            rsp_duty_in = raw_val[DUTY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_motor_ff <= rsp_motor_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_rev_ff   <= rsp_rev_in;
      rsp_clip_ff  <= rsp_clip_in;
   end

   assign sts.out_free        = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid          = rsp_valid_ff;
   assign rsp_motor_number    = rsp_motor_ff;
   assign rsp_duty_magnitude  = rsp_duty_ff;
   assign rsp_reverse_dir     = rsp_rev_ff;
   assign rsp_duty_clipped    = rsp_clip_ff;

   // Integral stays inside the anti-windup window after an update
   a_integ_clamped: assert property (@(posedge clock) disable iff (reset)
      cmd.integ |=> (integ_ff <= $signed({1'b0, $past(cfg.integ_limit)}))
                 && (integ_ff >= -$signed({1'b0, $past(cfg.integ_limit)})))
      else $error("integral outside anti-windup window");

   // A word is never loaded over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_tready))
      else $error("output word overwritten");

   // Loaded duty never exceeds the duty limit
   a_duty_limited: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (rsp_duty_ff <= $past(cfg.duty_limit)))
      else $error("duty above limit");

   // Unknown motor yields an all-zero command
   a_bad_motor_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && !ok_ff) |=> (rsp_duty_ff == '0) && !rsp_rev_ff && !rsp_clip_ff)
      else $error("nonzero command for unknown motor");

endmodule

`default_nettype wire

// ===== rtl/core/motor_current_pi_controller.sv =====
// Top level of the motor current PI controller with feedforward and anti-windup.
// Depends on mcpi_pkg, mcpi_csr, mcpi_ctrl and mcpi_datapath.
//
//   Channel  Dir  Handshake          Payload
//   req_     in   tvalid/tready      tuser: motor_index; tdata: sense_code,
//                                    encoder_speed, target_current
//   rsp_     out  tvalid/tready      tuser: motor_number; tdata: duty_magnitude,
//                                    reverse_dir, duty_clipped
//   csr_     in   psel/penable       7 registers at byte address 4*i
//
// A word is walked from acceptance to the output register by the sequencer: a single
// shared 17x33 multiplier is stepped through four gain products and two
// supply-scaling chunks. No new word is accepted while one is still in the steps.
// The next word is accepted once the sequencer is back in idle, even while the
// previous result waits on rsp_tready; a full output register stalls only the
// final step. Synchronous reset clears the integrals of all motors and restores
// the register defaults.
`default_nettype none

module motor_current_pi_controller #(
   parameter int MOTOR_COUNT = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // [15:0] sense_code, [35:16] encoder_speed,
                                         // [51:36] target_current, [55:52] zero
   input  wire logic [0:0]  req_tuser,   // [0] motor_index
   // Result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [11:0] duty_magnitude, [12] reverse_dir,
                                         // [13] duty_clipped, [15:14] zero
   output logic [0:0]       rsp_tuser,   // [0] motor_number
   // Configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   mcpi_pkg::cfg_type cfg;
   mcpi_pkg::cmd_type cmd;
   mcpi_pkg::sts_type sts;

   logic [11:0] duty_mag;
   logic        rev_dir;
   logic        clipped;
   logic        motor_num;

   mcpi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mcpi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mcpi_datapath #(
      .MOTOR_COUNT (MOTOR_COUNT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .sts                (sts),
      .req_motor          (req_tuser[0]),
      .req_sense_code     (req_tdata[15:0]),
      .req_encoder_speed  ($signed(req_tdata[35:16])),
      .req_target_current ($signed(req_tdata[51:36])),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_motor_number   (motor_num),
      .rsp_duty_magnitude (duty_mag),
      .rsp_reverse_dir    (rev_dir),
      .rsp_duty_clipped   (clipped)
   );

   // Result word packing
   assign rsp_tdata = {2'b00, clipped, rev_dir, duty_mag};
   assign rsp_tuser = motor_num;

endmodule

`default_nettype wire
